/* hdl/varint_run_length_block_decoder_defines.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the run-length block decoder
// Concurrent assertion wrappers; empty bodies when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef VARINT_RUN_LENGTH_BLOCK_DECODER_DEFINES_SVH
`define VARINT_RUN_LENGTH_BLOCK_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define VRLD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define VRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VRLD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define VRLD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hdl/vrld_pkg.sv */
// ---------------------------------------------------------------------------
// vrld_pkg
// Types, constants and helpers shared by the run-length block decoder.
// ---------------------------------------------------------------------------
package vrld_pkg;

    localparam int POS_W   = 23;
    localparam int VCNT_W  = 4;
    localparam int FILL_W  = 16;
    localparam int LIT_W   = 15;

    localparam logic [POS_W-1:0]  TOTAL_BLOCKS     = 23'h400000;
    localparam logic [POS_W:0]    TB_MINUS_ONE     = 24'h3FFFFF;
    localparam logic [POS_W-1:0]  GAP_MAX          = 23'h7FFFFF;
    localparam logic [VCNT_W-1:0] MAX_VARINT_BYTES = 4'd10;
    localparam logic [VCNT_W-1:0] SHIFT_BYTES      = 4'd4;

    // register indexes of the configuration port
    localparam logic CFG_REMOVED_FILL = 1'b0;
    localparam logic CFG_AIR_FILL     = 1'b1;

    typedef enum logic [1:0] {
        PH_VARINT  = 2'd0,
        PH_ID_LOW  = 2'd1,
        PH_ID_HIGH = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_POS_FULL     = 3'd1,
        ST_BAD_VARINT   = 3'd2,
        ST_RUN_OVERFLOW = 3'd3,
        ST_TRUNC_ID     = 3'd4
    } status_t;

    typedef struct packed {
        logic [FILL_W-1:0] fill_value;
        logic [POS_W-1:0]  fill_count;
        logic [LIT_W-1:0]  literal_id;
        logic              has_literal;
        status_t           status;
        logic              end_of_segment;
    } result_t;

    typedef struct packed {
        logic [FILL_W-1:0] removed_fill;
        logic [FILL_W-1:0] air_fill;
    } cfg_t;

    // results pushed by one byte transfer
    typedef struct packed {
        logic    push0;
        result_t res0;
        logic    push1;
        result_t res1;
    } push_t;

    typedef struct packed {
        logic [1:0] count;
        logic       room;
    } q_stat_t;

    function automatic result_t error_result(status_t code);
        result_t r;
        r                = '0;
        r.status         = code;
        r.end_of_segment = 1'b1;
        return r;
    endfunction

endpackage

/* hdl/vrld_ifs.sv */
// ---------------------------------------------------------------------------
// Channel interfaces
// Byte input, result output and configuration write channels.
// ---------------------------------------------------------------------------
interface vrld_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface vrld_result_if;
    logic        valid;
    logic        ready;
    logic [15:0] fill_value;
    logic [22:0] fill_count;
    logic [14:0] literal_id;
    logic        has_literal;
    logic [2:0]  status;
    logic        end_of_segment;

    modport source (output valid, output fill_value, output fill_count,
                    output literal_id, output has_literal, output status,
                    output end_of_segment, input ready);
    modport sink   (input valid, input fill_value, input fill_count,
                    input literal_id, input has_literal, input status,
                    input end_of_segment, output ready);
endinterface

interface vrld_cfg_if;
    logic        valid;
    logic        ready;
    logic        reg_index;
    logic [15:0] wr_data;

    modport source (output valid, output reg_index, output wr_data, input ready);
    modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

/* hdl/varint_run_length_block_decoder.sv */
// ---------------------------------------------------------------------------
// varint_run_length_block_decoder
// Byte-serial decoder for the run-length block section of a segment.
// ---------------------------------------------------------------------------
// Takes one byte per transfer, one transfer per cycle when not stalled. Records
// are a little-endian base-128 gap count then a 16-bit little-endian word (bit
// 15 picks removed_fill or air_fill, bits 14..0 the literal id). Each complete
// record gives one result in the cycle after its last byte; a record ending on
// the segment's last byte also gives a tail result filling the rest with air_fill.
// Errors give one result with end_of_segment set, then bytes are dropped up to
// the last byte. A byte may give two results, so the byte channel stalls while
// the two-entry result register is full, or while it holds one result that the
// result sink is not taking in the same cycle. Write configuration only while
// no results are pending.
// ---------------------------------------------------------------------------
`include "varint_run_length_block_decoder_defines.svh"

module varint_run_length_block_decoder (
    input  logic          clk,
    input  logic          rst_n,
    vrld_cfg_if.sink      cfg,
    vrld_byte_if.sink     bytes,
    vrld_result_if.source results
);

    vrld_pkg::cfg_t    cfg_q;
    vrld_pkg::push_t   push;
    vrld_pkg::q_stat_t q_stat;
    logic              xfer;

    // fill value registers
    vrld_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // byte transfer accepted when the result register can take two results
    assign bytes.ready = q_stat.room;
    assign xfer        = bytes.valid && bytes.ready;

    vrld_decoder u_dec (
        .clk       (clk),
        .rst_n     (rst_n),
        .xfer      (xfer),
        .data_byte (bytes.data_byte),
        .last_byte (bytes.last_byte),
        .cfg_q     (cfg_q),
        .push      (push)
    );

    // result register, two entries so the tail never stalls the record
    vrld_out_queue u_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .results (results),
        .q_stat  (q_stat)
    );

    // checks
    `VRLD_ASSERT_SAME(a_cnt_max, clk, rst_n, 1'b1, q_stat.count != 2'd3, "queue overfill")
    `VRLD_ASSERT_SAME(a_room, clk, rst_n, xfer, q_stat.count != 2'd2, "byte taken with full queue")
    `VRLD_ASSERT_SAME(a_tail_eos, clk, rst_n, results.valid && !results.has_literal,
        results.end_of_segment, "tail or error without end of segment")
    `VRLD_ASSERT_SAME(a_err_zero, clk, rst_n,
        results.valid && (results.status != vrld_pkg::ST_OK),
        (results.fill_count == '0) && !results.has_literal, "error result not cleared")
    `VRLD_ASSERT_NEXT(a_two_push, clk, rst_n, push.push1, q_stat.count == 2'd2,
        "record and tail not both queued")

endmodule

/* hdl/vrld_cfg_regs.sv */
// ---------------------------------------------------------------------------
// vrld_cfg_regs
// Fill value registers written over the configuration channel.
// ---------------------------------------------------------------------------
module vrld_cfg_regs (
    input  logic            clk,
    input  logic            rst_n,
    vrld_cfg_if.sink        cfg,
    output vrld_pkg::cfg_t  cfg_q
);

    vrld_pkg::cfg_t cfg_reg;
    vrld_pkg::cfg_t cfg_next;

    assign cfg.ready = 1'b1;
    assign cfg_q     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                vrld_pkg::CFG_REMOVED_FILL: cfg_next.removed_fill = cfg.wr_data;
                vrld_pkg::CFG_AIR_FILL:     cfg_next.air_fill     = cfg.wr_data;
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* hdl/vrld_decoder.sv */
// ---------------------------------------------------------------------------
// vrld_decoder
// Per-byte record parser: varint gap, id word, position and error tracking.
// ---------------------------------------------------------------------------
module vrld_decoder (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  xfer,
    input  logic [7:0]                            data_byte,
    input  logic                                  last_byte,
    input  vrld_pkg::cfg_t                        cfg_q,
    output vrld_pkg::push_t                       push
);

    localparam int PW = vrld_pkg::POS_W;

    vrld_pkg::phase_t             phase_reg, phase_next;
    logic [PW-1:0]                gap_reg, gap_next;
    logic                         sat_reg, sat_next;
    logic [vrld_pkg::VCNT_W-1:0]  cnt_reg, cnt_next;
    logic [7:0]                   id_low_reg, id_low_next;
    logic [PW-1:0]                pos_reg, pos_next;
    logic                         hold_reg, hold_next;

    logic [6:0]                   val;
    logic [29:0]                  shifted;
    logic [29:0]                  acc_or;
    logic                         sat_hit;
    logic [PW-1:0]                gap_upd;
    logic [vrld_pkg::VCNT_W-1:0]  cnt_inc;
    logic [PW:0]                  sum1;
    logic                         run_over;
    logic                         pos_full;
    logic [PW-1:0]                rest;
    logic                         bad_long;

    // varint accumulate: four 7-bit shift positions cover the 23-bit gap; higher bits saturate it
    assign val = data_byte[6:0];

    always_comb
    begin
        case (cnt_reg[1:0])
            2'd0:    shifted = {23'd0, val};
            2'd1:    shifted = {16'd0, val, 7'd0};
            2'd2:    shifted = {9'd0, val, 14'd0};
            2'd3:    shifted = {2'd0, val, 21'd0};
            default: shifted = '0;
        endcase
    end

    assign acc_or  = {7'd0, gap_reg} | shifted;
    assign sat_hit = (val != 7'd0) && !sat_reg &&
                     ((cnt_reg >= vrld_pkg::SHIFT_BYTES) || (acc_or[29:23] != 7'd0));
    assign gap_upd = ((val == 7'd0) || sat_reg) ? gap_reg :
                     (sat_hit ? vrld_pkg::GAP_MAX : acc_or[PW-1:0]);
    assign cnt_inc = cnt_reg + 4'd1;
    assign bad_long = data_byte[7] && ((cnt_inc >= vrld_pkg::MAX_VARINT_BYTES) || last_byte);

    // record end: position + gap + 1, overflow when position + gap + 2 reaches the end
    assign sum1     = {1'b0, pos_reg} + {1'b0, gap_reg} + 24'd1;
    assign run_over = sat_reg || (sum1 >= vrld_pkg::TB_MINUS_ONE);
    assign pos_full = (pos_reg >= vrld_pkg::TOTAL_BLOCKS);
    assign rest     = vrld_pkg::TOTAL_BLOCKS - sum1[PW-1:0];

    // next state
    always_comb
    begin
        logic restart;
        restart     = 1'b0;
        phase_next  = phase_reg;
        gap_next    = gap_reg;
        sat_next    = sat_reg;
        cnt_next    = cnt_reg;
        id_low_next = id_low_reg;
        pos_next    = pos_reg;
        hold_next   = hold_reg;
        if (xfer)
        begin
            if (hold_reg)
            begin
                restart = last_byte;
            end
            else
            begin
                case (phase_reg)
                    vrld_pkg::PH_ID_LOW:
                    begin
                        id_low_next = data_byte;
                        if (last_byte)
                            restart = 1'b1;
                        else
                            phase_next = vrld_pkg::PH_ID_HIGH;
                    end
                    vrld_pkg::PH_ID_HIGH:
                    begin
                        if (run_over)
                        begin
                            restart   = last_byte;
                            hold_next = 1'b1;
                        end
                        else
                        begin
                            pos_next    = sum1[PW-1:0];
                            phase_next  = vrld_pkg::PH_VARINT;
                            gap_next    = '0;
                            sat_next    = 1'b0;
                            cnt_next    = '0;
                            id_low_next = '0;
                            restart     = last_byte;
                        end
                    end
                    vrld_pkg::PH_VARINT:
                    begin
                        if ((cnt_reg == '0) && pos_full)
                        begin
                            restart   = last_byte;
                            hold_next = 1'b1;
                        end
                        else
                        begin
                            gap_next = gap_upd;
                            sat_next = sat_reg | sat_hit;
                            cnt_next = cnt_inc;
                            if (data_byte[7])
                            begin
                                if (bad_long)
                                begin
                                    restart   = last_byte;
                                    hold_next = 1'b1;
                                end
                            end
                            else if (last_byte)
                                restart = 1'b1;
                            else
                                phase_next = vrld_pkg::PH_ID_LOW;
                        end
                    end
                    default:
                    begin
                        phase_next = vrld_pkg::PH_VARINT;
                    end
                endcase
            end
        end
        if (restart)
        begin
            phase_next  = vrld_pkg::PH_VARINT;
            gap_next    = '0;
            sat_next    = 1'b0;
            cnt_next    = '0;
            id_low_next = '0;
            pos_next    = '0;
            hold_next   = 1'b0;
        end
    end

    // results
    always_comb
    begin
        push = '0;
        if (xfer && !hold_reg)
        begin
            case (phase_reg)
                vrld_pkg::PH_ID_LOW:
                begin
                    if (last_byte)
                    begin
                        push.push0 = 1'b1;
                        push.res0  = vrld_pkg::error_result(vrld_pkg::ST_TRUNC_ID);
                    end
                end
                vrld_pkg::PH_ID_HIGH:
                begin
                    push.push0 = 1'b1;
                    if (run_over)
                    begin
                        push.res0 = vrld_pkg::error_result(vrld_pkg::ST_RUN_OVERFLOW);
                    end
                    else
                    begin
                        push.res0.fill_value  = data_byte[7] ? cfg_q.removed_fill
                                                             : cfg_q.air_fill;
                        push.res0.fill_count  = gap_reg;
                        push.res0.literal_id  = {data_byte[6:0], id_low_reg};
                        push.res0.has_literal = 1'b1;
                        push.res0.status      = vrld_pkg::ST_OK;
                        if (last_byte)
                        begin
                            push.push1                = 1'b1;
                            push.res1.fill_value      = cfg_q.air_fill;
                            push.res1.fill_count      = rest;
                            push.res1.status          = vrld_pkg::ST_OK;
                            push.res1.end_of_segment  = 1'b1;
                        end
                    end
                end
                vrld_pkg::PH_VARINT:
                begin
                    if ((cnt_reg == '0) && pos_full)
                    begin
                        push.push0 = 1'b1;
                        push.res0  = vrld_pkg::error_result(vrld_pkg::ST_POS_FULL);
                    end
                    else if (bad_long || (!data_byte[7] && last_byte))
                    begin
                        push.push0 = 1'b1;
                        push.res0  = vrld_pkg::error_result(vrld_pkg::ST_BAD_VARINT);
                    end
                end
                default:
                begin
                    push = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= vrld_pkg::PH_VARINT;
            gap_reg    <= '0;
            sat_reg    <= 1'b0;
            cnt_reg    <= '0;
            id_low_reg <= '0;
            pos_reg    <= '0;
            hold_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            gap_reg    <= gap_next;
            sat_reg    <= sat_next;
            cnt_reg    <= cnt_next;
            id_low_reg <= id_low_next;
            pos_reg    <= pos_next;
            hold_reg   <= hold_next;
        end
    end

endmodule

/* hdl/vrld_out_queue.sv */
// ---------------------------------------------------------------------------
// vrld_out_queue
// Two-entry result register; takes up to two results per byte transfer.
// ---------------------------------------------------------------------------
module vrld_out_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  vrld_pkg::push_t   push,
    vrld_result_if.source     results,
    output vrld_pkg::q_stat_t q_stat
);

    vrld_pkg::result_t q0_reg, q0_next;
    vrld_pkg::result_t q1_reg, q1_next;
    logic [1:0]        count_reg, count_next;
    logic              pop;

    assign pop = results.valid && results.ready;

    // room for two results once the head leaves
    assign q_stat.count = count_reg;
    assign q_stat.room  = (count_reg == 2'd0) || ((count_reg == 2'd1) && results.ready);

    assign results.valid          = (count_reg != 2'd0);
    assign results.fill_value     = q0_reg.fill_value;
    assign results.fill_count     = q0_reg.fill_count;
    assign results.literal_id     = q0_reg.literal_id;
    assign results.has_literal    = q0_reg.has_literal;
    assign results.status         = q0_reg.status;
    assign results.end_of_segment = q0_reg.end_of_segment;

    always_comb
    begin
        logic [1:0] left;
        q0_next = q0_reg;
        q1_next = q1_reg;
        left    = count_reg;
        if (pop)
        begin
            q0_next = q1_reg;
            left    = count_reg - 2'd1;
        end
        count_next = left;
        if (push.push0)
        begin
            if (left == 2'd0)
            begin
                q0_next = push.res0;
                if (push.push1)
                    q1_next = push.res1;
            end
            else
            begin
                q1_next = push.res0;
            end
            count_next = left + {1'b0, push.push0} + {1'b0, push.push1};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q0_reg <= q0_next;
        q1_reg <= q1_next;
    end

endmodule

/* tb/vrld_run_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// vrld_run_checker
// Watches the configuration, byte and result channels of the run-length
// block decoder, predicts every result from the accepted bytes and compares
// the results in order, field by field.
// ---------------------------------------------------------------------------
module vrld_run_checker
    import vrld_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    vrld_cfg_if    cfg,
    vrld_byte_if   bytes,
    vrld_result_if results,
    output int     fail_count,
    output int     pending,
    output int     live_bytes,
    output int     result_count,
    output int     error_count,
    output int     tail_count
);

    // predicted register copy and segment state
    logic [FILL_W-1:0] removed_fill;
    logic [FILL_W-1:0] air_fill;
    phase_t            seg_phase;
    logic [POS_W-1:0]  gap_acc;
    logic              gap_sat;
    logic [VCNT_W-1:0] varint_len;
    logic [7:0]        id_low;
    logic [POS_W-1:0]  fill_pos;
    logic              dropping;

    result_t expected_runs[$];

    int fails;
    int decoded;
    int seen;
    int errors;
    int tails;

    task automatic clear_segment();
        seg_phase  = PH_VARINT;
        gap_acc    = '0;
        gap_sat    = 1'b0;
        varint_len = '0;
        id_low     = '0;
        fill_pos   = '0;
        dropping   = 1'b0;
    endtask

    task automatic post_error(input status_t code, input logic last);
        result_t run;
        run                = '0;
        run.status         = code;
        run.end_of_segment = 1'b1;
        expected_runs.push_back(run);
        errors++;
        if (last)
            clear_segment();
        else
            dropping = 1'b1;
    endtask

    task automatic decode_byte(input logic [7:0] b, input logic last);
        logic [15:0]      word;
        logic [POS_W+1:0] reach;
        logic [63:0]      merged;
        result_t          run;
        if (dropping)
        begin
            if (last)
                clear_segment();
        end
        else if (seg_phase == PH_ID_LOW)
        begin
            decoded++;
            id_low = b;
            if (last)
                post_error(ST_TRUNC_ID, 1'b1);
            else
                seg_phase = PH_ID_HIGH;
        end
        else if (seg_phase == PH_ID_HIGH)
        begin
            decoded++;
            word  = {b, id_low};
            reach = (POS_W+2)'(fill_pos) + (POS_W+2)'(gap_acc) + (POS_W+2)'(2);
            if (gap_sat || reach >= TOTAL_BLOCKS)
                post_error(ST_RUN_OVERFLOW, last);
            else
            begin
                run             = '0;
                run.fill_value  = word[15] ? removed_fill : air_fill;
                run.fill_count  = gap_acc;
                run.literal_id  = word[14:0];
                run.has_literal = 1'b1;
                run.status      = ST_OK;
                expected_runs.push_back(run);
                fill_pos   = fill_pos + gap_acc + 1'b1;
                seg_phase  = PH_VARINT;
                gap_acc    = '0;
                gap_sat    = 1'b0;
                varint_len = '0;
                id_low     = '0;
                if (last)
                begin
                    // air fill up to the end of the segment
                    run                = '0;
                    run.fill_value     = air_fill;
                    run.fill_count     = (fill_pos < TOTAL_BLOCKS) ?
                                         TOTAL_BLOCKS - fill_pos : '0;
                    run.status         = ST_OK;
                    run.end_of_segment = 1'b1;
                    expected_runs.push_back(run);
                    tails++;
                    clear_segment();
                end
            end
        end
        else
        begin
            decoded++;
            if (varint_len == '0 && fill_pos >= TOTAL_BLOCKS)
                post_error(ST_POS_FULL, last);
            else
            begin
                if (b[6:0] != 7'd0 && !gap_sat)
                begin
                    if (varint_len >= SHIFT_BYTES)
                        gap_sat = 1'b1;
                    else
                    begin
                        merged = 64'(gap_acc) | (64'(b[6:0]) << (7 * varint_len));
                        if (merged > 64'(GAP_MAX))
                            gap_sat = 1'b1;
                        else
                            gap_acc = merged[POS_W-1:0];
                    end
                    if (gap_sat)
                        gap_acc = GAP_MAX;
                end
                varint_len = varint_len + 1'b1;
                if (b[7])
                begin
                    if (varint_len >= MAX_VARINT_BYTES || last)
                        post_error(ST_BAD_VARINT, last);
                end
                else if (last)
                    post_error(ST_BAD_VARINT, 1'b1);
                else
                    seg_phase = PH_ID_LOW;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h actual %0h",
                     $time, field, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            removed_fill = '0;
            air_fill     = '0;
            clear_segment();
            expected_runs.delete();
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.reg_index == CFG_REMOVED_FILL)
                    removed_fill = cfg.wr_data;
                else
                    air_fill = cfg.wr_data;
            end
            // results first: a byte accepted at this edge cannot be answered yet
            if (results.valid && results.ready)
            begin
                seen++;
                if (expected_runs.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result, expected none actual %h/%h/%h/%b/%h/%b",
                             $time, results.fill_value, results.fill_count,
                             results.literal_id, results.has_literal,
                             results.status, results.end_of_segment);
                end
                else
                begin
                    want = expected_runs.pop_front();
                    check_field("fill_value", 32'(want.fill_value),
                                32'(results.fill_value));
                    check_field("fill_count", 32'(want.fill_count),
                                32'(results.fill_count));
                    check_field("literal_id", 32'(want.literal_id),
                                32'(results.literal_id));
                    check_field("has_literal", 32'(want.has_literal),
                                32'(results.has_literal));
                    check_field("status", 32'(want.status), 32'(results.status));
                    check_field("end_of_segment", 32'(want.end_of_segment),
                                32'(results.end_of_segment));
                end
            end
            if (bytes.valid && bytes.ready)
                decode_byte(bytes.data_byte, bytes.last_byte);
        end
        fail_count   <= fails;
        pending      <= expected_runs.size();
        live_bytes   <= decoded;
        result_count <= seen;
        error_count  <= errors;
        tail_count   <= tails;
    end

endmodule

/* tb/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the run-length block decoder: directed segments
// for the corner cases, then random segments under three idle patterns, with
// a separate checker predicting and comparing every result transfer.
// ---------------------------------------------------------------------------
module tb;
    import vrld_pkg::*;

    localparam int          CYCLE_LIMIT   = 400000;
    localparam int          SETTLE_CYCLES = 8;     // result is registered, so it trails its byte
    localparam int          HOLD_CYCLES   = 400;   // long result-side stall
    localparam int          CHUNK_BYTES   = 135;   // minimum decoded bytes per random chunk
    localparam int unsigned BLOCKS        = TOTAL_BLOCKS;

    // Segment shapes for the random part. Most are well formed; the rest end
    // in one of the error paths or are plain noise.
    typedef enum int {
        SEG_CLEAN       = 0,
        SEG_CUT_VARINT  = 1,
        SEG_CUT_ID      = 2,
        SEG_LONG_VARINT = 3,
        SEG_SATURATED   = 4,
        SEG_OVERFLOW    = 5,
        SEG_NOISE       = 6
    } seg_kind_t;

    logic clk;
    logic rst_n;

    vrld_cfg_if    cfg_ch();
    vrld_byte_if   byte_ch();
    vrld_result_if res_ch();

    int fail_count;
    int pending;
    int live_bytes;
    int result_count;
    int error_count;
    int tail_count;

    int cycle_count   = 0;
    int segments      = 0;
    int cfg_writes    = 0;
    int send_idle_pct = 22;
    int recv_idle_pct = 88;
    bit hold_req      = 1'b0;

    logic [7:0] seg_q[$];   // bytes of the segment being built

    varint_run_length_block_decoder i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_ch),
        .bytes   (byte_ch),
        .results (res_ch)
    );

    vrld_run_checker i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_ch),
        .bytes        (byte_ch),
        .results      (res_ch),
        .fail_count   (fail_count),
        .pending      (pending),
        .live_bytes   (live_bytes),
        .result_count (result_count),
        .error_count  (error_count),
        .tail_count   (tail_count)
    );

    // 20 ns clock
    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog: a hang anywhere ends the run as a failure.
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, pending);
        $display("** varint_run_length_block_decoder: FAILED **");
        $finish;
    end

    // Result sink. Ready is rolled fresh every cycle against the current idle
    // percentage; a hold request from the stimulus forces a long stall that is
    // counted down here, so the sender keeps offering bytes meanwhile.
    initial
    begin : result_sink
        int hold_left;
        hold_left    = 0;
        res_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Send the queued segment, one byte transfer at a time; the final byte
    // carries last_byte. Valid stays high between bytes unless an idle roll
    // hits, so back-to-back transfers happen too.
    task automatic send_segment();
        int k;
        for (k = 0; k < seg_q.size(); k++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                byte_ch.valid <= 1'b0;
                @(posedge clk);
            end
            byte_ch.valid     <= 1'b1;
            byte_ch.data_byte <= seg_q[k];
            byte_ch.last_byte <= (k == seg_q.size() - 1);
            do
                @(posedge clk);
            while (byte_ch.ready !== 1'b1);
        end
        seg_q.delete();
        segments++;
    endtask

    // Sender pause: wait until every predicted result has been taken, then
    // leave room for a byte that is still in flight but yields nothing.
    task automatic drain_results();
        byte_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Both fill registers, written back to back while the decoder is idle.
    task automatic set_fills(input logic [15:0] removed, input logic [15:0] air);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= CFG_REMOVED_FILL;
        cfg_ch.wr_data   <= removed;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.reg_index <= CFG_AIR_FILL;
        cfg_ch.wr_data   <= air;
        do
            @(posedge clk);
        while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        cfg_writes += 2;
    endtask

    // LEB128 gap count. A nonzero pad stretches the encoding with zero-valued
    // continuation bytes, which the decoder must accept up to ten bytes.
    task automatic append_varint(input logic [31:0] val, input int pad);
        logic [31:0] rest;
        rest = val;
        while (rest > 32'd127)
        begin
            seg_q.push_back({1'b1, rest[6:0]});
            rest = rest >> 7;
        end
        if (pad == 0)
            seg_q.push_back({1'b0, rest[6:0]});
        else
        begin
            seg_q.push_back({1'b1, rest[6:0]});
            repeat (pad - 1)
                seg_q.push_back(8'h80);
            seg_q.push_back(8'h00);
        end
    endtask

    // id word, little endian; bit 15 picks removed or air fill
    task automatic append_word();
        logic [15:0] w;
        w = 16'($urandom);
        seg_q.push_back(w[7:0]);
        seg_q.push_back(w[15:8]);
    endtask

    task automatic append_noise(input int count);
        repeat (count)
            seg_q.push_back(8'($urandom));
    endtask

    // Gap that keeps the record inside the segment: mostly short runs, now
    // and then one that lands exactly on the last legal position.
    function automatic int unsigned pick_gap(input int unsigned at);
        int unsigned room;
        int unsigned g;
        int          roll;
        room = (at + 3 <= BLOCKS) ? BLOCKS - 3 - at : 0;
        roll = $urandom_range(99);
        if (roll < 55)
            g = $urandom_range(15);
        else if (roll < 85)
            g = $urandom_range(3000, 16);
        else if (roll < 97)
            g = $urandom_range(500000, 3001);
        else
            g = room;
        return (g > room) ? room : g;
    endfunction

    task automatic build_segment();
        seg_kind_t   kind;
        int          roll;
        int          n;
        int          k;
        int unsigned at;
        int unsigned g;
        logic [31:0] v;
        roll = $urandom_range(99);
        if (roll < 64)
            kind = SEG_CLEAN;
        else
            kind = seg_kind_t'(1 + (roll - 64) / 6);
        // well-formed records first; faulty segments get a shorter prefix
        at = 0;
        n  = (kind == SEG_CLEAN) ? $urandom_range(6, 1) : $urandom_range(3);
        if (kind == SEG_NOISE)
            n = 0;
        for (k = 0; k < n; k++)
        begin
            g = pick_gap(at);
            append_varint(g, ($urandom_range(7) == 0) ? $urandom_range(6, 1) : 0);
            append_word();
            at = at + g + 1;
        end
        case (kind)
            SEG_CUT_VARINT:
            begin
                // stream ends inside the gap count
                repeat ($urandom_range(2))
                    seg_q.push_back(8'h80 | 8'($urandom));
                seg_q.push_back(8'($urandom));
            end
            SEG_CUT_ID:
            begin
                // stream ends on the low byte of the id word
                append_varint($urandom_range(200), 0);
                seg_q.push_back(8'($urandom));
            end
            SEG_LONG_VARINT:
            begin
                // continuation still set on the tenth byte
                repeat (MAX_VARINT_BYTES)
                    seg_q.push_back(8'h80 | 8'($urandom));
                append_noise($urandom_range(4));
            end
            SEG_SATURATED:
            begin
                // gap wider than 23 bits
                v = $urandom;
                v[23 + $urandom_range(8)] = 1'b1;
                append_varint(v, 0);
                append_word();
                append_noise($urandom_range(4));
            end
            SEG_OVERFLOW:
            begin
                // run reaching or passing the end of the segment
                g = ((at + 2 <= BLOCKS) ? BLOCKS - 2 - at : 0) + $urandom_range(2);
                append_varint(g, 0);
                append_word();
                append_noise($urandom_range(4));
            end
            SEG_NOISE:
                append_noise($urandom_range(12, 1));
            default:
                ;
        endcase
    endtask

    initial
    begin : stimulus
        int p;
        int target;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = 8'h00;
        byte_ch.last_byte = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.reg_index  = CFG_REMOVED_FILL;
        cfg_ch.wr_data    = 16'h0000;
        rst_n             = 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed segments ----
        set_fills(16'hFFFF, 16'h0000);
        // zero gap, flag clear, on the last byte: record then tail
        seg_q = '{8'h00, 8'h00, 8'h00};
        send_segment();
        // largest gap that still fits, flag set, widest literal id
        seg_q = '{8'hFD, 8'hFF, 8'hFF, 8'h01, 8'hFF, 8'hFF};
        send_segment();
        drain_results();

        set_fills(16'h0000, 16'hFFFF);
        // one more: run overflow exactly at the segment end
        seg_q = '{8'hFE, 8'hFF, 8'hFF, 8'h01, 8'h34, 8'h92};
        send_segment();
        // gap count cut off by the end of the stream
        seg_q = '{8'h85};
        send_segment();
        // id word cut off after its low byte
        seg_q = '{8'h00, 8'h12};
        send_segment();
        // nonzero group past the fourth varint byte saturates the gap
        seg_q = '{8'h80, 8'h80, 8'h80, 8'h80, 8'h01, 8'h34, 8'h12};
        send_segment();

        // ---- random segments, three idle patterns, two chunks each ----
        for (p = 0; p < 3; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            repeat (2)
            begin
                drain_results();
                set_fills(16'($urandom), 16'($urandom));
                // with no idling, stall the result side for a long stretch so
                // the result register fills and the byte channel backs up
                if (p == 2 && !hold_req)
                    hold_req = 1'b1;
                target = live_bytes + CHUNK_BYTES;
                while (live_bytes < target)
                begin
                    build_segment();
                    send_segment();
                end
            end
        end

        drain_results();
        $display("Covered %0d decoded byte transfers in %0d segments, %0d fill register writes",
                 live_bytes, segments, cfg_writes);
        $display("Checked %0d result transfers: %0d errors, %0d tail fills",
                 result_count, error_count, tail_count);
        if (fail_count == 0 && pending == 0)
            $display("** varint_run_length_block_decoder: PASSED **");
        else
            $display("** varint_run_length_block_decoder: FAILED **");
        $finish;
    end

endmodule
